// ----- rtl/core/voxel_grid_first_point_filter_top_macros.svh -----
// Assertion macros for the voxel grid filter
`ifndef VOXEL_GRID_FIRST_POINT_FILTER_TOP_MACROS_SVH
`define VOXEL_GRID_FIRST_POINT_FILTER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define VG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VG_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VG_ASSERT(lbl, clk, rst, prop, msg)
`define VG_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/vgfp_pkg.sv -----
// -----------------------------------------------------------------------------
// vgfp_pkg
// Shared types and constants for the voxel grid first-point filter.
// -----------------------------------------------------------------------------
`default_nettype none
package vgfp_pkg;
   localparam int unsigned COORD_W  = 32;
   localparam int unsigned STAMP_W  = 64;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned FOLD_W   = 20;
   // power of two: home slot and probe stepping wrap on the address width
   localparam int unsigned TABLE_DEPTH = 4096;
   localparam logic [31:0] INV_RESET = 32'd655360;
   localparam logic [0:0]  REG_INV_VOXEL = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_HASH, ST_CLEAR, ST_RD, ST_CMP, ST_OUT
   } state_type;

   typedef struct packed {
      logic                      start_of_frame;
      logic                      coord_valid;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [STAMP_W-1:0]        stamp_bits;
      logic [BYTE_W-1:0]         tag_in;
      logic [BYTE_W-1:0]         line_in;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] kept_x;
      logic signed [COORD_W-1:0] kept_y;
      logic signed [COORD_W-1:0] kept_z;
      logic [STAMP_W-1:0]        kept_stamp;
      logic [BYTE_W-1:0]         kept_tag;
      logic [BYTE_W-1:0]         kept_line;
      logic                      table_overflow;
   } rsp_type;
endpackage
`default_nettype wire

// ----- rtl/core/vgfp_stream_if.sv -----
// -----------------------------------------------------------------------------
// vgfp_stream_if
// Valid/ready channel carrying one payload struct.
// -----------------------------------------------------------------------------
`default_nettype none
interface vgfp_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/voxel_grid_first_point_filter_top.sv -----
// -----------------------------------------------------------------------------
// voxel_grid_first_point_filter_top
// Keeps the first lidar point seen in each voxel since start of frame.
// -----------------------------------------------------------------------------
// channel  dir  payload        handshake
// req      in   req_type       valid/ready
// rsp      out  rsp_type       valid/ready
// csr      in   inv_voxel_size APB, pready tied high
//
// One shared 32x33 multiplier forms the three cell indices, one per cycle.
// Each probe is a RAM read step then a compare step; a repeat gives no result.
// Start of frame retires an epoch; every 15th one wraps the counter and a
// sweep over all TABLE_DEPTH slots clears the epoch marks before the point goes on.
// Reset runs the same sweep; an invalid point gives no result.
// A waiting result holds the block until it is taken.
// -----------------------------------------------------------------------------
`default_nettype none
`include "voxel_grid_first_point_filter_top_macros.svh"
module voxel_grid_first_point_filter_top
   import vgfp_pkg::*;
#(
   parameter int unsigned PROBE_LIMIT   = 8,
   parameter int unsigned AXIS_KEY_BITS = 21
) (
   input  wire logic clock,
   input  wire logic reset,
   vgfp_stream_if.sink   req,
   vgfp_stream_if.source rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [0:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   localparam int unsigned AW    = $clog2(TABLE_DEPTH);
   localparam int unsigned KW    = 3 * AXIS_KEY_BITS;
   localparam int unsigned PW    = $clog2(PROBE_LIMIT + 1);
   localparam int unsigned EW    = 4;
   localparam logic [AXIS_KEY_BITS-1:0] OFFSET =
      AXIS_KEY_BITS'(1) << (AXIS_KEY_BITS - 1);

   // Configuration register (byte address 0 -> paddr bit 0 is 0)
   logic [31:0] inv_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_INV_VOXEL) ? inv_ff : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) inv_ff <= INV_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_INV_VOXEL)
         inv_ff <= csr_pwdata;
   end

   state_type state_ff, state_in;
   req_type   item_ff;
   rsp_type   out_ff;
   logic      out_valid_ff, out_valid_in;
   logic [1:0] axis_ff, axis_in;
   logic [KW-1:0] key_ff;
   logic [AW-1:0] slot_ff, slot_in;
   logic [PW-1:0] probe_ff, probe_in;
   logic [EW-1:0] epoch_ff, epoch_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [63:0]   prod_ff;

   // Epoch store (one mark per slot) and key store
   logic          ep_we, key_we;
   logic [AW-1:0] ep_addr;
   logic [EW-1:0] ep_wdata, ep_rd;
   logic [KW-1:0] key_rd;

   vgfp_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_epoch (
      .clock(clock), .wr_en(ep_we), .addr(ep_addr), .wr_data(ep_wdata),
      .rd_data(ep_rd));
   vgfp_ram #(.WIDTH(KW), .DEPTH(TABLE_DEPTH)) u_keys (
      .clock(clock), .wr_en(key_we), .addr(slot_ff), .wr_data(key_ff),
      .rd_data(key_rd));

   // Shared multiplier input
   logic signed [31:0] mul_a;
   always_comb begin
      case (axis_ff)
         2'd0:    mul_a = item_ff.pos_x;
         2'd1:    mul_a = item_ff.pos_y;
         default: mul_a = item_ff.pos_z;
      endcase
   end

   // Cell field of the last product; the key shifts it in from the top
   logic [AXIS_KEY_BITS-1:0] field;
   logic [KW-1:0]            key_full;
   assign field    = AXIS_KEY_BITS'(prod_ff[63:32]) + OFFSET;
   assign key_full = {field, key_ff[KW-1:AXIS_KEY_BITS]};

   // Hash of the completed key (z field joins in the hash step)
   logic [63:0] k64;
   logic [FOLD_W-1:0] fold;
   always_comb begin
      k64  = 64'(key_full);
      fold = FOLD_W'(k64 ^ (k64 >> 20) ^ (k64 >> 40) ^ (k64 >> 60));
   end

   logic slot_live;
   assign slot_live = (ep_rd == epoch_ff);

   // Start of frame on the last epoch value forces a sweep
   logic epoch_wrap;
   assign epoch_wrap = req.data.start_of_frame && epoch_ff == '1;

   logic pend_ff;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      epoch_in     = epoch_ff;
      sweep_in     = sweep_ff;
      out_valid_in = out_valid_ff;
      ep_we        = 1'b0;
      ep_addr      = slot_ff;
      ep_wdata     = epoch_ff;
      key_we       = 1'b0;
      req.ready    = 1'b0;
      if (rsp.ready) out_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = !out_valid_ff;
            axis_in   = 2'd0;
            if (req.valid && !out_valid_ff) begin
               if (req.data.start_of_frame)
                  epoch_in = epoch_wrap ? EW'(1) : epoch_ff + EW'(1);
               if (epoch_wrap) begin
                  sweep_in = '0;
                  state_in = ST_CLEAR;
               end else if (req.data.coord_valid) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            axis_in = axis_ff + 2'd1;
            if (axis_ff == 2'd2) state_in = ST_HASH;
         end
         ST_HASH: begin
            slot_in  = AW'(fold % TABLE_DEPTH);
            probe_in = '0;
            state_in = ST_RD;
         end
         ST_CLEAR: begin
            ep_we    = 1'b1;
            ep_addr  = sweep_ff;
            ep_wdata = '0;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == AW'(TABLE_DEPTH - 1))
               state_in = pend_ff ? ST_MUL : ST_IDLE;
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!slot_live) begin
               ep_we    = 1'b1;
               key_we   = 1'b1;
               state_in = ST_OUT;
            end else if (key_rd == key_ff) begin
               state_in = ST_IDLE;
            end else if (probe_ff == PW'(PROBE_LIMIT - 1)) begin
               state_in = ST_OUT;
            end else begin
               probe_in = probe_ff + PW'(1);
               slot_in  = slot_ff + AW'(1);
               state_in = ST_RD;
            end
         end
         ST_OUT: begin
            out_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic item_take;
   assign item_take = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         out_valid_ff <= 1'b0;
         axis_ff      <= '0;
         probe_ff     <= '0;
         epoch_ff     <= EW'(1);
         sweep_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         axis_ff      <= axis_in;
         probe_ff     <= probe_in;
         epoch_ff     <= epoch_in;
         sweep_ff     <= sweep_in;
      end
   end

   // Wrap sweep must restart the point afterwards: hold a pending flag
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 1'b0;
      else if (item_take)
         pend_ff <= req.data.coord_valid && epoch_wrap;
      else if (state_ff == ST_CLEAR && sweep_ff == AW'(TABLE_DEPTH - 1))
         pend_ff <= 1'b0;
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (item_take) item_ff <= req.data;
      if (state_ff == ST_MUL)
         prod_ff <= 64'($signed(mul_a) * $signed({1'b0, inv_ff}));
      if (state_ff == ST_MUL && axis_ff != 2'd0)
         key_ff <= key_full;
      if (state_ff == ST_HASH)
         key_ff <= key_full;
      slot_ff <= slot_in;
      if (state_ff == ST_CMP && slot_live && key_rd != key_ff
          && probe_ff == PW'(PROBE_LIMIT - 1))
         out_ff.table_overflow <= 1'b1;
      if (state_ff == ST_CMP && !slot_live)
         out_ff.table_overflow <= 1'b0;
      if (state_ff == ST_OUT) begin
         out_ff.kept_x     <= item_ff.pos_x;
         out_ff.kept_y     <= item_ff.pos_y;
         out_ff.kept_z     <= item_ff.pos_z;
         out_ff.kept_stamp <= item_ff.stamp_bits;
         out_ff.kept_tag   <= item_ff.tag_in;
         out_ff.kept_line  <= item_ff.line_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   `VG_ASSERT(a_no_take_busy, clock, reset, item_take |-> !out_valid_ff,
      "item taken while result pending")
   `VG_ASSERT(a_probe_bound, clock, reset, probe_ff <= PW'(PROBE_LIMIT - 1),
      "probe count beyond limit")
   `VG_ASSERT(a_out_from_out, clock, reset,
      $rose(out_valid_ff) |-> $past(state_ff) == ST_OUT,
      "result without output step")
endmodule
`default_nettype wire

// ----- rtl/core/vgfp_ram.sv -----
// -----------------------------------------------------------------------------
// vgfp_ram
// Generic single-port RAM with registered read.
// -----------------------------------------------------------------------------
`default_nettype none
module vgfp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire
